@@ rtl/wavp_pkg.sv @@
// Shared types and constants for the WAV header parser.
// Phase codes, error codes, register indexes and RIFF tag words.
// No dependencies.
package wavp_pkg;

    // RIFF tags, little-endian byte order packed into one word
    localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
    localparam logic [31:0] FMT_BASE_LEN = 32'd16;

    // register reset values
    localparam logic [15:0] RST_FORMAT   = 16'd1;
    localparam logic [15:0] RST_CHANNELS = 16'd1;
    localparam logic [31:0] RST_RATE     = 32'd22050;
    localparam logic [15:0] RST_ALIGN    = 16'd1;

    // configuration register indexes
    localparam logic [7:0] CFG_FORMAT   = 8'd0;
    localparam logic [7:0] CFG_CHANNELS = 8'd1;
    localparam logic [7:0] CFG_RATE     = 8'd2;
    localparam logic [7:0] CFG_ALIGN    = 8'd3;

    // latched error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TAG       = 3'd1;
    localparam logic [2:0] ERR_FORMAT    = 3'd2;
    localparam logic [2:0] ERR_EARLY_END = 3'd3;
    localparam logic [2:0] ERR_PAST_END  = 3'd4;

    typedef enum logic [16:0] {
        PH_RIFF       = 17'h0_0001,
        PH_RIFF_LEN   = 17'h0_0002,
        PH_WAVE       = 17'h0_0004,
        PH_FMT        = 17'h0_0008,
        PH_FMT_LEN    = 17'h0_0010,
        PH_FORMAT     = 17'h0_0020,
        PH_CHANNELS   = 17'h0_0040,
        PH_RATE       = 17'h0_0080,
        PH_AVG        = 17'h0_0100,
        PH_ALIGN      = 17'h0_0200,
        PH_BITS       = 17'h0_0400,
        PH_FMT_EXTRA  = 17'h0_0800,
        PH_CHUNK_ID   = 17'h0_1000,
        PH_CHUNK_LEN  = 17'h0_2000,
        PH_CHUNK_SKIP = 17'h0_4000,
        PH_DATA_LEN   = 17'h0_8000,
        PH_DATA       = 17'h1_0000
    } t_phase;

    typedef struct packed {
        logic [15:0] format;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] align;
    } t_cfg;

    typedef struct packed {
        logic [7:0] sample;
        logic       sample_valid;
        logic       last_sample;
        logic       header_done;
        logic [2:0] error_code;
    } t_result;

    // byte idx of a packed tag word
    function automatic logic [7:0] tag_byte(input logic [31:0] word, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = word[31:24];
        endcase
        return b;
    endfunction

endpackage

@@ rtl/wavp_cfg.sv @@
// Configuration register bank for the WAV header parser.
// Depends on wavp_pkg.
module wavp_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_cfg_ready,
    output wavp_pkg::t_cfg     o_cfg
);
    import wavp_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.format   <= RST_FORMAT;
            r_cfg.channels <= RST_CHANNELS;
            r_cfg.rate     <= RST_RATE;
            r_cfg.align    <= RST_ALIGN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FORMAT:   r_cfg.format   <= i_cfg_data[15:0];
                CFG_CHANNELS: r_cfg.channels <= i_cfg_data[15:0];
                CFG_RATE:     r_cfg.rate     <= i_cfg_data;
                CFG_ALIGN:    r_cfg.align    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/wavp_core.sv @@
// Parser state and next-state logic: one file byte per accepted word.
// Depends on wavp_pkg.
module wavp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    input  wavp_pkg::t_cfg      i_cfg,
    output wavp_pkg::t_result   o_res
);
    import wavp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_fv, n_fv;
    logic [31:0] r_fmt_len, n_fmt_len;
    logic [31:0] r_skip, n_skip;
    logic [31:0] r_data, n_data;
    logic [2:0]  r_error, n_error;
    logic        r_mismatch, n_mismatch;

    logic [31:0] col_val;
    logic        done4, done2;
    logic [1:0]  idx_inc;
    logic [31:0] tag_word;
    t_phase      tag_next;
    logic [31:0] skip_dec;

    // little-endian field assembly
    assign col_val  = (r_idx == 2'd0) ? {24'd0, i_byte}
                                      : (r_fv | ({24'd0, i_byte} << {r_idx, 3'b000}));
    assign done4    = (r_idx == 2'd3);
    assign done2    = (r_idx != 2'd0);
    assign idx_inc  = r_idx + 2'd1;
    assign skip_dec = r_skip - {31'd0, (r_skip != 32'd0)};

    always_comb begin
        case (r_phase)
            PH_RIFF: begin
                tag_word = TAG_RIFF;
                tag_next = PH_RIFF_LEN;
            end
            PH_WAVE: begin
                tag_word = TAG_WAVE;
                tag_next = PH_FMT;
            end
            default: begin
                tag_word = TAG_FMT;
                tag_next = PH_FMT_LEN;
            end
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_fv       = r_fv;
        n_fmt_len  = r_fmt_len;
        n_skip     = r_skip;
        n_data     = r_data;
        n_error    = r_error;
        n_mismatch = r_mismatch;
        o_res      = '0;

        if (r_error == ERR_NONE) begin
            if (i_end) begin
                if (r_phase != PH_DATA) begin
                    n_error = ERR_EARLY_END;
                end
            end else if (r_phase == PH_DATA) begin
                if (r_data == 32'd0) begin
                    n_error = ERR_PAST_END;
                end else begin
                    o_res.sample       = i_byte;
                    o_res.sample_valid = 1'b1;
                    o_res.last_sample  = (r_data == 32'd1);
                    n_data             = r_data - 32'd1;
                end
            end else begin
                case (r_phase)
                    PH_RIFF, PH_WAVE, PH_FMT: begin
                        if (i_byte != tag_byte(tag_word, r_idx)) begin
                            n_error = ERR_TAG;
                        end else if (done4) begin
                            n_idx   = 2'd0;
                            n_phase = tag_next;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                    PH_RIFF_LEN, PH_AVG: begin
                        n_fv  = col_val;
                        n_idx = done4 ? 2'd0 : idx_inc;
                        if (done4) begin
                            n_phase = (r_phase == PH_AVG) ? PH_ALIGN : PH_WAVE;
                        end
                    end
                    PH_FMT_LEN: begin
                        n_fv  = col_val;
                        n_idx = done4 ? 2'd0 : idx_inc;
                        if (done4) begin
                            n_fmt_len = col_val;
                            n_phase   = PH_FORMAT;
                        end
                    end
                    PH_FORMAT: begin
                        n_fv  = col_val;
                        n_idx = done2 ? 2'd0 : idx_inc;
                        if (done2) begin
                            if (col_val != {16'd0, i_cfg.format}) n_mismatch = 1'b1;
                            n_phase = PH_CHANNELS;
                        end
                    end
                    PH_CHANNELS: begin
                        n_fv  = col_val;
                        n_idx = done2 ? 2'd0 : idx_inc;
                        if (done2) begin
                            if (col_val != {16'd0, i_cfg.channels}) n_mismatch = 1'b1;
                            n_phase = PH_RATE;
                        end
                    end
                    PH_RATE: begin
                        n_fv  = col_val;
                        n_idx = done4 ? 2'd0 : idx_inc;
                        if (done4) begin
                            // format/channel mismatch reported together with rate
                            if (r_mismatch || (col_val != i_cfg.rate)) n_error = ERR_FORMAT;
                            n_phase = PH_AVG;
                        end
                    end
                    PH_ALIGN: begin
                        n_fv  = col_val;
                        n_idx = done2 ? 2'd0 : idx_inc;
                        if (done2) begin
                            if (col_val != {16'd0, i_cfg.align}) n_error = ERR_FORMAT;
                            n_phase = PH_BITS;
                        end
                    end
                    PH_BITS: begin
                        n_fv  = col_val;
                        n_idx = done2 ? 2'd0 : idx_inc;
                        if (done2) begin
                            if (r_fmt_len > FMT_BASE_LEN) begin
                                n_skip  = r_fmt_len - FMT_BASE_LEN;
                                n_phase = PH_FMT_EXTRA;
                            end else begin
                                n_phase = PH_CHUNK_ID;
                            end
                        end
                    end
                    PH_FMT_EXTRA, PH_CHUNK_SKIP: begin
                        n_skip = skip_dec;
                        if (skip_dec == 32'd0) n_phase = PH_CHUNK_ID;
                    end
                    PH_CHUNK_ID: begin
                        n_fv  = col_val;
                        n_idx = done4 ? 2'd0 : idx_inc;
                        if (done4) begin
                            n_phase = (col_val == TAG_DATA) ? PH_DATA_LEN : PH_CHUNK_LEN;
                        end
                    end
                    PH_CHUNK_LEN: begin
                        n_fv  = col_val;
                        n_idx = done4 ? 2'd0 : idx_inc;
                        if (done4) begin
                            n_skip  = col_val;
                            n_phase = (col_val == 32'd0) ? PH_CHUNK_ID : PH_CHUNK_SKIP;
                        end
                    end
                    PH_DATA_LEN: begin
                        n_fv  = col_val;
                        n_idx = done4 ? 2'd0 : idx_inc;
                        if (done4) begin
                            n_data  = col_val;
                            n_phase = PH_DATA;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        o_res.header_done = (n_phase == PH_DATA);
        o_res.error_code  = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_idx      <= 2'd0;
            r_fv       <= '0;
            r_fmt_len  <= '0;
            r_skip     <= '0;
            r_data     <= '0;
            r_error    <= ERR_NONE;
            r_mismatch <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_fv       <= n_fv;
            r_fmt_len  <= n_fmt_len;
            r_skip     <= n_skip;
            r_data     <= n_data;
            r_error    <= n_error;
            r_mismatch <= n_mismatch;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error != ERR_NONE) |=> (r_error == $past(r_error)))
        else $error("latched error changed");

    a_phase_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error != ERR_NONE) |=> $stable(r_phase))
        else $error("phase moved after error");

    a_sample_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res.sample_valid) |-> (r_phase == PH_DATA && r_data != 32'd0))
        else $error("sample outside data chunk");

    a_last_when_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.last_sample |-> (o_res.sample_valid && r_data == 32'd1))
        else $error("last sample flag without final byte");

endmodule

@@ rtl/wav_header_parser.sv @@
// Top level of the WAV header parser: handshakes, output register.
// Depends on wavp_pkg, wavp_cfg and wavp_core.
//
// Usage:
//   Input channel: one file byte per word (i_file_byte) with i_stream_end
//   flagging that the source has run dry. A word is taken on a rising edge
//   with i_in_valid high and o_in_stall low.
//   Output channel: exactly one result word per input word (sample byte,
//   sample/last flags, header_done, latched error code), taken on a rising
//   edge with o_out_valid high and i_out_stall low.
//   Config channel: i_cfg_valid/o_cfg_ready with a register index and data;
//   ready is always high. Write only while the parser is idle.
// Timing and throughput:
//   A result is registered in the cycle after its byte is taken. One byte per
//   cycle sustained while i_out_stall is low: the whole parse step is one pass
//   of compare/decrement logic between the parser state and output registers.
// Reset (synchronous, active low): parser returns to expecting the RIFF tag,
//   errors clear, registers return to PCM / 1 channel / 22050 Hz / align 1,
//   and the output register empties.
// Stall: while the output word waits under i_out_stall, o_in_stall is high and
//   no byte is taken; once the output word leaves, a new byte may be taken in
//   the same cycle.
module wav_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_stream_end,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_sample,
    output logic        o_sample_valid,
    output logic        o_last_sample,
    output logic        o_header_done,
    output logic [2:0]  o_error_code,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import wavp_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    logic    accept;

    // take a byte whenever the output slot is empty or draining this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    wavp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    wavp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_file_byte),
        .i_end    (i_stream_end),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_res.sample;
    assign o_sample_valid = r_res.sample_valid;
    assign o_last_sample  = r_res.last_sample;
    assign o_header_done  = r_res.header_done;
    assign o_error_code   = r_res.error_code;

    a_sample_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.sample_valid) |-> (r_res.header_done && r_res.error_code == ERR_NONE))
        else $error("sample word without completed header");

    a_no_take_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_res)))
        else $error("held result overwritten");

endmodule
